@@ rtl/dfd_pkg.sv @@
// Shared types and constants for the delimited frame deframer.
// Used by dfd_msg_buf, dfd_frame_store and delimited_frame_deframer; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dfd_pkg;

   // buffer sizes
   localparam int MSG_BYTES   = 256;
   localparam int FRAME_BYTES = 256;

   // derived widths
   localparam int BYTE_W = 8;
   localparam int PAT_W  = 32;
   localparam int MSG_AW = $clog2(MSG_BYTES);
   localparam int FS_AW  = $clog2(FRAME_BYTES);
   localparam int WP_W   = $clog2(MSG_BYTES + 1);
   localparam int FS_CW  = $clog2(FRAME_BYTES + 1);
   localparam int CNT_W  = ((WP_W > FS_CW) ? WP_W : FS_CW) + 1;

   // stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAD_W  = RSP_DATA_W - 2 * BYTE_W - 1;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_PATTERN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PATTERN   = 1'b1;

   // request operations
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   // message buffer port
   typedef struct packed {
      logic              wr_en;
      logic [MSG_AW-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [MSG_AW-1:0] rd_addr;
      logic              rd_hit;
   } msg_port_type;

   // frame store port
   typedef struct packed {
      logic              wr_en;
      logic [FS_AW-1:0]  wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [FS_AW-1:0]  rd_addr;
      logic              rd_hit;
   } fs_port_type;

endpackage

`default_nettype wire

@@ rtl/dfd_msg_buf.sv @@
// Message buffer memory: one write and one registered read port per cycle.
// Depends on dfd_pkg for sizes and the port struct.
`timescale 1ns / 1ps
`default_nettype none

module dfd_msg_buf (
   input  wire                        clock,
   input  wire dfd_pkg::msg_port_type port,
   output logic [dfd_pkg::BYTE_W-1:0] rd_data
);
   import dfd_pkg::*;

   logic [BYTE_W-1:0] mem [MSG_BYTES];
   logic [BYTE_W-1:0] data_ff;
   logic              hit_ff;

   // write port
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
   end

   // read port, entries past the valid limit read as zero
   always_ff @(posedge clock) begin
      if (port.rd_en) begin
         data_ff <= mem[port.rd_addr];
         hit_ff  <= port.rd_hit;
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/dfd_frame_store.sv @@
// Frame store memory: holds the latest copied frame, registered read.
// Depends on dfd_pkg for sizes and the port struct.
`timescale 1ns / 1ps
`default_nettype none

module dfd_frame_store (
   input  wire                        clock,
   input  wire dfd_pkg::fs_port_type  port,
   output logic [dfd_pkg::BYTE_W-1:0] rd_data
);
   import dfd_pkg::*;

   logic [BYTE_W-1:0] mem [FRAME_BYTES];
   logic [BYTE_W-1:0] data_ff;
   logic              hit_ff;

   // write port
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_addr] <= port.wr_data;
      end
   end

   // read port, entries never written read as zero
   always_ff @(posedge clock) begin
      if (port.rd_en) begin
         data_ff <= mem[port.rd_addr];
         hit_ff  <= port.rd_hit;
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/delimited_frame_deframer.sv @@
// Top level of the delimited frame deframer: window match, sequencer, output register.
// Depends on dfd_pkg, dfd_msg_buf and dfd_frame_store.
`timescale 1ns / 1ps
`default_nettype none

// Received bytes shift through a four-byte window that is compared with the start and
// end delimiters. Bytes between them collect in a message buffer; on the end delimiter
// buffer byte 0 gives a length and that many following bytes are copied, one per cycle,
// into a frame store that read requests address. One request is worked on at a time;
// a byte that completes the end delimiter also runs the copy of a frame of length L (at
// most 255), which walks the single read port of the message buffer. Both memories
// come out of reset ready for use: valid limits stand in for clearing, so no clearing
// pass runs. A result waits in the output register while the next request is taken.

module delimited_frame_deframer (
   input  wire                                clock,
   input  wire                                reset,
   // request: rx_byte [7:0], read_index [15:8]
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [dfd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request: operation [0]
   input  wire                                req_tuser,
   // response: frame_length [7:0], in_frame [8], read_data [16:9], zeros above
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [dfd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // response: frame_done
   output logic                               rsp_tlast,
   // register write port
   input  wire                                csr_wr_en,
   input  wire  [dfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [dfd_pkg::PAT_W-1:0]          csr_wdata
);
   import dfd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_LEN  = 5'b00100,
      ST_COPY = 5'b01000,
      ST_PUSH = 5'b10000
   } state_type;

   // control state
   state_type          state_ff, state_in;
   logic [PAT_W-1:0]   start_pattern_ff, start_pattern_in;
   logic [PAT_W-1:0]   end_pattern_ff, end_pattern_in;
   logic [PAT_W-1:0]   window_ff, window_in;
   logic               collecting_ff, collecting_in;
   logic [WP_W-1:0]    wp_ff, wp_in;
   logic [WP_W-1:0]    vlim_ff, vlim_in;
   logic [BYTE_W-1:0]  stored_len_ff, stored_len_in;
   logic [FS_CW-1:0]   fs_fill_ff, fs_fill_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload state
   logic               done_ff, done_in;
   logic [BYTE_W-1:0]  rdata_ff, rdata_in;
   logic [FS_CW-1:0]   copy_n_ff, copy_n_in;
   logic [FS_CW-1:0]   idx_ff, idx_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   // memory ports
   msg_port_type       msg_port;
   fs_port_type        fs_port;
   logic [BYTE_W-1:0]  msg_rd_data;
   logic [BYTE_W-1:0]  fs_rd_data;

   logic               req_fire;
   logic               rsp_free;

   dfd_msg_buf u_msg_buf (
      .clock   (clock),
      .port    (msg_port),
      .rd_data (msg_rd_data)
   );

   dfd_frame_store u_frame_store (
      .clock   (clock),
      .port    (fs_port),
      .rd_data (fs_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // register writes
   always_comb begin
      start_pattern_in = start_pattern_ff;
      end_pattern_in   = end_pattern_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_PATTERN: start_pattern_in = csr_wdata;
            CSR_END_PATTERN:   end_pattern_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // request sequencer
   always_comb begin
      logic [PAT_W-1:0]  win_n;
      logic [CNT_W-1:0]  src;
      logic [CNT_W-1:0]  len_ext;
      logic [FS_CW-1:0]  n;

      win_n   = {req_tdata[BYTE_W-1:0], window_ff[PAT_W-1:BYTE_W]};
      src     = '0;
      len_ext = CNT_W'(msg_rd_data);
      n       = (len_ext < CNT_W'(FRAME_BYTES)) ? FS_CW'(len_ext) : FS_CW'(FRAME_BYTES);

      state_in      = state_ff;
      window_in     = window_ff;
      collecting_in = collecting_ff;
      wp_in         = wp_ff;
      vlim_in       = vlim_ff;
      stored_len_in = stored_len_ff;
      fs_fill_in    = fs_fill_ff;
      done_in       = done_ff;
      rdata_in      = rdata_ff;
      copy_n_in     = copy_n_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      msg_port      = '0;
      fs_port       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == OP_READ) begin
                  // frame store read, unwritten entries give zero
                  fs_port.rd_en   = 1'b1;
                  fs_port.rd_addr = FS_AW'(req_tdata[REQ_DATA_W-1:BYTE_W]);
                  fs_port.rd_hit  = CNT_W'(req_tdata[REQ_DATA_W-1:BYTE_W])
                                    < CNT_W'(fs_fill_ff);
                  done_in         = 1'b0;
                  state_in        = ST_READ;
               end else begin
                  window_in = win_n;
                  rdata_in  = '0;
                  done_in   = 1'b0;
                  state_in  = ST_PUSH;
                  if (win_n == start_pattern_ff) begin
                     // start delimiter: restart with an empty buffer
                     collecting_in = 1'b1;
                     wp_in         = '0;
                     vlim_in       = '0;
                  end else if (win_n == end_pattern_ff) begin
                     // end delimiter: drop the last three positions, fetch the length
                     collecting_in = 1'b0;
                     vlim_in       = (wp_ff >= WP_W'(3)) ? wp_ff - WP_W'(3) : '0;
                     msg_port.rd_en   = 1'b1;
                     msg_port.rd_addr = '0;
                     msg_port.rd_hit  = (vlim_in != '0);
                     done_in          = 1'b1;
                     state_in         = ST_LEN;
                  end else if (collecting_ff && (wp_ff < WP_W'(MSG_BYTES))) begin
                     // store while collecting and not full
                     msg_port.wr_en   = 1'b1;
                     msg_port.wr_addr = MSG_AW'(wp_ff);
                     msg_port.wr_data = req_tdata[BYTE_W-1:0];
                     wp_in            = wp_ff + WP_W'(1);
                     vlim_in          = wp_ff + WP_W'(1);
                  end
               end
            end
         end

         ST_READ: begin
            rdata_in = fs_rd_data;
            state_in = ST_PUSH;
         end

         ST_LEN: begin
            // length byte arrived, start the copy
            stored_len_in = msg_rd_data;
            copy_n_in     = n;
            idx_in        = '0;
            if (n > fs_fill_ff) begin
               fs_fill_in = n;
            end
            if (n == '0) begin
               state_in = ST_PUSH;
            end else begin
               src              = CNT_W'(1);
               msg_port.rd_en   = 1'b1;
               msg_port.rd_addr = MSG_AW'(src);
               msg_port.rd_hit  = src < CNT_W'(vlim_ff);
               state_in         = ST_COPY;
            end
         end

         ST_COPY: begin
            // one byte per cycle from buffer position idx+1 to frame position idx
            fs_port.wr_en   = 1'b1;
            fs_port.wr_addr = FS_AW'(idx_ff);
            fs_port.wr_data = msg_rd_data;
            if ((CNT_W'(idx_ff) + CNT_W'(1)) < CNT_W'(copy_n_ff)) begin
               src              = CNT_W'(idx_ff) + CNT_W'(2);
               msg_port.rd_en   = 1'b1;
               msg_port.rd_addr = MSG_AW'(src);
               msg_port.rd_hit  = src < CNT_W'(vlim_ff);
               idx_in           = idx_ff + FS_CW'(1);
            end else begin
               state_in = ST_PUSH;
            end
         end

         ST_PUSH: begin
            // hand the result to the output register
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, rdata_ff, collecting_ff, stored_len_ff};
               rsp_last_in  = done_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         start_pattern_ff <= '0;
         end_pattern_ff   <= '0;
         window_ff        <= '0;
         collecting_ff    <= 1'b1;
         wp_ff            <= '0;
         vlim_ff          <= '0;
         stored_len_ff    <= '0;
         fs_fill_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         start_pattern_ff <= start_pattern_in;
         end_pattern_ff   <= end_pattern_in;
         window_ff        <= window_in;
         collecting_ff    <= collecting_in;
         wp_ff            <= wp_in;
         vlim_ff          <= vlim_in;
         stored_len_ff    <= stored_len_in;
         fs_fill_ff       <= fs_fill_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      done_ff     <= done_in;
      rdata_ff    <= rdata_in;
      copy_n_ff   <= copy_n_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking bench for delimited_frame_deframer: a directed table, then random traffic
// in several delimiter settings, checked against a predictor of the deframer.
// Depends on dfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb;
   import dfd_pkg::*;

   // one result as the response channel carries it
   typedef struct packed {
      logic              done;
      logic [7:0]        len;
      logic              inf;
      logic [7:0]        rd;
   } deframe_result_type;

   // one request, with an optional hand-typed result
   typedef struct packed {
      logic               op;
      logic [7:0]         rx;
      logic [7:0]         ri;
      logic               chk;
      deframe_result_type exp;
   } deframe_req_type;

   typedef enum logic { ROW_REQ, ROW_REG } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  op;
      logic [7:0]            rx;
      logic [7:0]            ri;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [PAT_W-1:0]      reg_val;
      logic                  chk;
      deframe_result_type    exp;
   } dir_row_type;

   localparam deframe_result_type NO_RES = '0;
   // longest quiet stretch of a good run: hold-off, a full copy, both idles
   localparam int QUIET_LIMIT = 5000;
   localparam int DIR_ROWS = 27;

   // directed table: start A0 B1 C2 D3, end B1 C2 D3 E4 so the end can close on
   // the byte right after the start delimiter
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      // out of reset, both delimiters zero
      '{ROW_REQ, OP_READ,    8'hFF, 8'h00, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 0, 1, 0}},
      '{ROW_REQ, OP_READ,    8'h00, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 0, 1, 0}},
      // zero byte matches both delimiters, start wins
      '{ROW_REQ, OP_RECEIVE, 8'h00, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 0, 1, 0}},
      '{ROW_REG, OP_RECEIVE, 8'h00, 8'h00, CSR_START_PATTERN, 32'hD3C2B1A0, 1'b0, NO_RES},
      '{ROW_REG, OP_RECEIVE, 8'h00, 8'h00, CSR_END_PATTERN,   32'hE4D3C2B1, 1'b0, NO_RES},
      // well-formed frame of three bytes
      '{ROW_REQ, OP_RECEIVE, 8'hA0, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hB1, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hC2, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hD3, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'h03, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hFF, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'h00, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'h7F, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hB1, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hC2, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hD3, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hE4, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b1, '{1, 3, 0, 0}},
      // frame store readback, top index never written
      '{ROW_REQ, OP_READ,    8'h00, 8'h00, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 3, 0, 8'hFF}},
      '{ROW_REQ, OP_READ,    8'hFF, 8'h01, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 3, 0, 8'h00}},
      '{ROW_REQ, OP_READ,    8'h00, 8'h02, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 3, 0, 8'h7F}},
      '{ROW_REQ, OP_READ,    8'hFF, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 3, 0, 8'h00}},
      // end right after start: zeroing runs below position zero
      '{ROW_REQ, OP_RECEIVE, 8'hA0, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hB1, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hC2, 8'h00, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hD3, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b0, NO_RES},
      '{ROW_REQ, OP_RECEIVE, 8'hE4, 8'h00, CSR_START_PATTERN, 32'h0, 1'b1, '{1, 0, 0, 0}},
      // not collecting: byte only moves the window
      '{ROW_REQ, OP_RECEIVE, 8'h00, 8'hFF, CSR_START_PATTERN, 32'h0, 1'b1, '{0, 0, 0, 0}}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [PAT_W-1:0]       csr_wdata;

   delimited_frame_deframer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // predictor state
   logic [PAT_W-1:0]  start_pat;
   logic [PAT_W-1:0]  end_pat;
   logic [31:0]       win;
   logic              collecting;
   int                wpos;
   logic [7:0]        msg_buf [MSG_BYTES];
   logic [7:0]        frame_mem [FRAME_BYTES];
   logic [7:0]        stored_len;

   // request queue, results still owed, bookkeeping
   deframe_req_type     req_queue [$];
   deframe_result_type  pending_results [$];
   deframe_req_type     cur_req;
   int                req_sent;
   int                req_taken;
   int                n_queued;
   int                n_errors;
   int                n_results;
   int                n_reads;
   int                n_frames;
   int                n_settings;
   int                rsp_hold_req;
   bit                rsp_fired;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // expected result of one request, advancing the predictor state
   function automatic deframe_result_type deframe_predict(input logic op,
                                                          input logic [7:0] rx,
                                                          input logic [7:0] ri);
      deframe_result_type r;
      int len;
      r = '0;
      if (op == OP_READ) begin
         if (ri < FRAME_BYTES) r.rd = frame_mem[ri];
      end else begin
         win = {rx, win[31:8]};
         if (win == start_pat) begin
            collecting = 1'b1;
            wpos = 0;
            foreach (msg_buf[i]) msg_buf[i] = 8'h00;
         end else begin
            if (win == end_pat) begin
               collecting = 1'b0;
               // wipe the collected end delimiter, skipping positions off the buffer
               for (int k = 0; k < 4; k++)
                  if (wpos >= k && wpos - k < MSG_BYTES) msg_buf[wpos - k] = 8'h00;
               len = msg_buf[0];
               for (int i = 0; i < len && i < FRAME_BYTES; i++)
                  frame_mem[i] = (i + 1 < MSG_BYTES) ? msg_buf[i + 1] : 8'h00;
               stored_len = 8'(len);
               r.done = 1'b1;
            end
            if (collecting && wpos < MSG_BYTES) begin
               msg_buf[wpos] = rx;
               wpos++;
            end
         end
      end
      r.len = stored_len;
      r.inf = collecting;
      return r;
   endfunction

   function automatic void note_error(string msg);
      n_errors++;
      if (n_errors <= 10) $display("ERROR: %s", msg);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got)
         note_error($sformatf("result %0d, %s: expected %0h, got %0h", n_results, name,
                              want, got));
   endfunction

   // scoreboard: results first, then the request taken at the same edge
   always @(posedge clock) begin : scoreboard
      deframe_result_type got;
      deframe_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tlast, rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[16:9]};
            rsp_fired = 1'b1;
            if (got.done) n_frames++;
            if (pending_results.size() == 0) begin
               note_error($sformatf("result %0d arrived with nothing expected", n_results));
            end else begin
               want = pending_results.pop_front();
               check_field("frame_done", want.done, got.done);
               check_field("frame_length", want.len, got.len);
               check_field("in_frame", want.inf, got.inf);
               check_field("read_data", want.rd, got.rd);
               check_field("padding", 0, int'(rsp_tdata >> 17));
            end
            n_results++;
         end
         if (req_tvalid && req_tready) begin
            want = deframe_predict(req_tuser, req_tdata[7:0], req_tdata[15:8]);
            if (cur_req.chk) want = cur_req.exp;
            if (req_tuser == OP_READ) n_reads++;
            pending_results.push_back(want);
            req_taken++;
         end
      end
   end

   // request driver: one item at a time, random gap after each acceptance
   initial begin : sender
      int gap_left;
      bit fast;
      gap_left = 0;
      fast = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_RECEIVE;
      cur_req = '0;
      forever begin
         @(negedge clock);
         if (!reset && !(req_tvalid && req_taken != req_sent)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid = 1'b0;
            end else if (req_queue.size() != 0) begin
               cur_req = req_queue.pop_front();
               req_tuser = cur_req.op;
               req_tdata = {cur_req.ri, cur_req.rx};
               req_tvalid = 1'b1;
               req_sent++;
               if ($urandom_range(0, 63) == 0) fast = !fast;
               gap_left = fast ? 0 : $urandom_range(0, 7);
            end else begin
               req_tvalid = 1'b0;
            end
         end
      end
   end

   // response sink: random stall after each result, plus a long hold-off on demand
   initial begin : receiver
      int stall_left;
      int hold_left;
      bit fast;
      stall_left = 0;
      hold_left = 0;
      fast = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (rsp_fired) begin
            rsp_fired = 1'b0;
            if ($urandom_range(0, 63) == 0) fast = !fast;
            stall_left = fast ? 0 : $urandom_range(0, 7);
         end
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transfer for %0d cycles, %0d results outstanding", quiet,
               pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic push_rx(input logic [7:0] b);
      req_queue.push_back('{OP_RECEIVE, b, 8'($urandom), 1'b0, NO_RES});
      n_queued++;
   endtask

   task automatic push_read(input logic [7:0] idx);
      req_queue.push_back('{OP_READ, 8'($urandom), idx, 1'b0, NO_RES});
      n_queued++;
   endtask

   // start delimiter, length byte, payload, end delimiter
   task automatic push_frame(input logic [31:0] s, input logic [31:0] e,
                             input logic [7:0] len, input int count);
      for (int k = 0; k < 4; k++) push_rx(s[8*k +: 8]);
      push_rx(len);
      repeat (count) push_rx(8'($urandom));
      for (int k = 0; k < 4; k++) push_rx(e[8*k +: 8]);
   endtask

   // wait until every request is taken and every result is back
   task automatic wait_idle();
      while (req_queue.size() != 0 || req_taken != req_sent || pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx == CSR_START_PATTERN) start_pat = val;
      else end_pat = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // mostly complete frames with readback, the rest noise, cut-off frames and random reads
   task automatic random_traffic(input logic [31:0] s, input logic [31:0] e, input int count);
      int target;
      int pick;
      int len;
      int n;
      int hi;
      target = n_queued + count;
      while (n_queued < target) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
         if (pick < 60) begin
            // length byte now and then disagrees with the payload
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len + 5) : len;
            push_frame(s, e, 8'(len), n);
            hi = (len + 1 > 255) ? 255 : len + 1;
            repeat ($urandom_range(1, 3)) push_read(8'($urandom_range(0, hi)));
         end else if (pick < 75) begin
            repeat ($urandom_range(1, 8)) push_rx(8'($urandom));
         end else if (pick < 85) begin
            // partial or full start, then a frame that never closes, with part of an end delimiter at most
            n = $urandom_range(2, 4);
            for (int k = 0; k < n; k++) push_rx(s[8*k +: 8]);
            repeat ($urandom_range(0, 6)) push_rx(8'($urandom));
            n = $urandom_range(0, 3);
            for (int k = 0; k < n; k++) push_rx(e[8*k +: 8]);
            push_rx(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4)) push_read(8'($urandom));
         end
      end
   endtask

   initial begin : main
      logic [31:0] s;
      logic [31:0] e;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      start_pat = '0;
      end_pat = '0;
      win = '0;
      collecting = 1'b1;
      wpos = 0;
      stored_len = '0;
      foreach (msg_buf[i]) msg_buf[i] = 8'h00;
      foreach (frame_mem[i]) frame_mem[i] = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (DIR_TAB[i]) begin
         if (DIR_TAB[i].kind == ROW_REG) begin
            wait_idle();
            write_reg(DIR_TAB[i].reg_idx, DIR_TAB[i].reg_val);
         end else begin
            req_queue.push_back('{DIR_TAB[i].op, DIR_TAB[i].rx, DIR_TAB[i].ri,
                                  DIR_TAB[i].chk, DIR_TAB[i].exp});
            n_queued++;
         end
      end
      n_settings = 2;

      // random phases, each under its own delimiters, idle in between
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         case (p)
            0: begin
               s = '1;
               e = '0;
            end
            2: begin
               s = '0;
               e = '1;
            end
            3: begin
               // end delimiter overlaps the tail of the start delimiter
               s = $urandom;
               e = {8'($urandom), s[31:8]};
            end
            default: begin
               s = $urandom;
               e = $urandom;
            end
         endcase
         write_reg(CSR_START_PATTERN, s);
         write_reg(CSR_END_PATTERN, e);
         n_settings++;
         // long receiver hold-off while requests keep coming
         if (p == 1) rsp_hold_req = 400;
         // overrun of the message buffer
         if (p == 0) push_frame(s, e, 8'($urandom), MSG_BYTES + 6);
         // longest frame
         if (p == 2) push_frame(s, e, 8'd255, 255);
         random_traffic(s, e, 200);
      end

      wait_idle();
      repeat (300) @(posedge clock);
      if (pending_results.size() != 0)
         note_error($sformatf("%0d results never arrived", pending_results.size()));
      $display("run: %0d requests (%0d frame reads), %0d frames closed, %0d results",
               req_taken, n_reads, n_frames, n_results);
      $display("     %0d delimiter settings, %0d errors", n_settings, n_errors);
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
